/* sv/cubic_bisection_root_finder_macros.svh */
// Assertion macros shared by the cubic bisection root finder checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef CUBIC_BISECTION_ROOT_FINDER_MACROS_SVH
`define CUBIC_BISECTION_ROOT_FINDER_MACROS_SVH

// Checks the consequent in the same cycle as the antecedent.
`define CBRF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks the consequent in the cycle after the antecedent.
`define CBRF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/cbrf_pkg.sv */
// Shared types and constants of the cubic bisection root finder.
// Used by the controller, the datapath, the top level and the checker.
package cbrf_pkg;

   localparam int DATA_W             = 32;
   localparam int ACC_W              = 48;
   localparam int MUL_A_W            = 25;
   localparam int PROD_W             = 57;
   localparam int TOL_W              = 31;
   localparam int CSR_DATA_W         = 32;
   localparam int CSR_ADDR_W         = 3;
   localparam int ITERATIONS_DEFAULT = 32;

   // Register index, taken from the word address bit of paddr.
   localparam logic CSR_IDX_TOLERANCE = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_ACC,
      ST_TEST,
      ST_MID,
      ST_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      SEL_SQUARE,
      SEL_LINEAR,
      SEL_CONST
   } coef_sel_type;

   typedef struct packed {
      logic         load;
      logic         mid;
      logic         mul_lo;
      logic         mul_hi;
      logic         add;
      logic         acc;
      coef_sel_type coef_sel;
      logic         update;
      logic         out_write;
      logic         out_early;
   } dp_cmd_type;

   typedef struct packed {
      logic p_pos;
      logic p_in_tol;
      logic out_free;
   } dp_status_type;

endpackage

/* sv/cbrf_ctrl.sv */
// Controller of the cubic bisection root finder: sequences the Horner steps,
// the tolerance test and the bisection loop. Depends on cbrf_pkg.
module cbrf_ctrl #(
   parameter int ITERATIONS = cbrf_pkg::ITERATIONS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  cbrf_pkg::dp_status_type status,
   output cbrf_pkg::dp_cmd_type    cmd
);

   localparam int ITER_W = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ITERATIONS - 1);

   cbrf_pkg::state_type    state_ff, state_in;
   cbrf_pkg::coef_sel_type term_ff, term_in;
   logic [ITER_W-1:0]      iter_ff, iter_in;
   logic                   first_ff, first_in;
   logic                   early_ff, early_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbrf_pkg::ST_IDLE;
         term_ff  <= cbrf_pkg::SEL_SQUARE;
         iter_ff  <= '0;
         first_ff <= 1'b0;
         early_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
         iter_ff  <= iter_in;
         first_ff <= first_in;
         early_ff <= early_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      term_in      = term_ff;
      iter_in      = iter_ff;
      first_in     = first_ff;
      early_in     = early_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.coef_sel = term_ff;
      cmd.out_early = early_ff;

      unique case (state_ff)
         cbrf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               term_in  = cbrf_pkg::SEL_SQUARE;
               first_in = 1'b1;
               state_in = cbrf_pkg::ST_MUL_LO;
            end
         end
         cbrf_pkg::ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = cbrf_pkg::ST_MUL_HI;
         end
         cbrf_pkg::ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = cbrf_pkg::ST_SUM;
         end
         cbrf_pkg::ST_SUM: begin
            cmd.add  = 1'b1;
            state_in = cbrf_pkg::ST_ACC;
         end
         cbrf_pkg::ST_ACC: begin
            cmd.acc = 1'b1;
            unique case (term_ff)
               cbrf_pkg::SEL_SQUARE: begin
                  term_in  = cbrf_pkg::SEL_LINEAR;
                  state_in = cbrf_pkg::ST_MUL_LO;
               end
               cbrf_pkg::SEL_LINEAR: begin
                  term_in  = cbrf_pkg::SEL_CONST;
                  state_in = cbrf_pkg::ST_MUL_LO;
               end
               default: begin
                  state_in = cbrf_pkg::ST_TEST;
               end
            endcase
         end
         cbrf_pkg::ST_TEST: begin
            if (first_ff) begin
               // The first evaluation is at the right end and only decides
               // whether the bisection runs at all.
               first_in = 1'b0;
               iter_in  = '0;
               if (status.p_in_tol) begin
                  early_in = 1'b1;
                  state_in = cbrf_pkg::ST_OUTPUT;
               end else begin
                  state_in = cbrf_pkg::ST_MID;
               end
            end else begin
               cmd.update = 1'b1;
               if (iter_ff == ITER_LAST) begin
                  early_in = 1'b0;
                  state_in = cbrf_pkg::ST_OUTPUT;
               end else begin
                  iter_in  = iter_ff + 1'b1;
                  state_in = cbrf_pkg::ST_MID;
               end
            end
         end
         cbrf_pkg::ST_MID: begin
            cmd.mid  = 1'b1;
            term_in  = cbrf_pkg::SEL_SQUARE;
            state_in = cbrf_pkg::ST_MUL_LO;
         end
         cbrf_pkg::ST_OUTPUT: begin
            if (status.out_free) begin
               cmd.out_write = 1'b1;
               state_in      = cbrf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cbrf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* sv/cbrf_datapath.sv */
// Datapath of the cubic bisection root finder: operand registers, one shared
// 25x32 multiplier, the saturating Horner accumulator and the result register.
// Depends on cbrf_pkg.
module cbrf_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  cbrf_pkg::dp_cmd_type                    cmd,
   output cbrf_pkg::dp_status_type                 status,
   input  logic        [cbrf_pkg::TOL_W-1:0]       tolerance,
   input  logic signed [cbrf_pkg::DATA_W-1:0]      req_coef_const,
   input  logic signed [cbrf_pkg::DATA_W-1:0]      req_coef_linear,
   input  logic signed [cbrf_pkg::DATA_W-1:0]      req_coef_square,
   input  logic signed [cbrf_pkg::DATA_W-1:0]      req_coef_cube,
   input  logic signed [cbrf_pkg::DATA_W-1:0]      req_left_end,
   input  logic signed [cbrf_pkg::DATA_W-1:0]      req_right_end,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [cbrf_pkg::DATA_W-1:0]      rsp_root,
   output logic                                    rsp_right_was_root
);

   localparam int DW = cbrf_pkg::DATA_W;
   localparam int AW = cbrf_pkg::ACC_W;
   localparam int PW = cbrf_pkg::PROD_W;
   localparam int MW = cbrf_pkg::MUL_A_W;
   localparam int FRAC_SPLIT = 24;
   localparam int TH_W = PW - FRAC_SPLIT;
   localparam int SH_W = PW - 4;
   localparam int TOT_W = SH_W + 1;
   localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
   localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

   // Payload registers need no reset.
   logic signed [DW-1:0] c0_ff, c1_ff, c2_ff, c3_ff;
   logic signed [DW-1:0] feas_ff, feas_in;
   logic signed [DW-1:0] infeas_ff, infeas_in;
   logic signed [DW-1:0] x_ff, x_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [TH_W-1:0] th_ff, th_in;
   logic signed [PW-1:0] sum_ff, sum_in;
   logic signed [DW-1:0] root_ff, root_in;
   logic                 flag_ff, flag_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic signed [MW-1:0]   mul_a;
   logic signed [PW-1:0]   mul_res;
   logic signed [DW:0]     ends_sum;
   logic signed [DW-1:0]   mid_point;
   logic signed [DW-1:0]   coef;
   logic signed [TOT_W-1:0] total;
   logic signed [AW-1:0]   total_sat;
   logic signed [AW:0]     acc_ext;
   logic        [AW:0]     abs_p;

   // The accumulator is split into a signed high part and an unsigned low
   // part of 24 bits so that each product fits the shared multiplier.
   assign mul_a   = cmd.mul_lo ? {1'b0, acc_ff[FRAC_SPLIT-1:0]}
                               : {acc_ff[AW-1], acc_ff[AW-1:FRAC_SPLIT]};
   assign mul_res = PW'(mul_a) * PW'(x_ff);

   assign ends_sum  = (DW+1)'(feas_ff) + (DW+1)'(infeas_ff);
   assign mid_point = ends_sum[DW:1];

   always_comb begin
      case (cmd.coef_sel)
         cbrf_pkg::SEL_SQUARE: coef = c2_ff;
         cbrf_pkg::SEL_LINEAR: coef = c1_ff;
         default:              coef = c0_ff;
      endcase
   end

   assign total = TOT_W'($signed(sum_ff[PW-1:4])) + TOT_W'(coef);

   always_comb begin
      if (total[TOT_W-1:AW-1] == '0 || total[TOT_W-1:AW-1] == '1) begin
         total_sat = total[AW-1:0];
      end else if (total[TOT_W-1]) begin
         total_sat = ACC_MIN;
      end else begin
         total_sat = ACC_MAX;
      end
   end

   assign acc_ext = (AW+1)'(acc_ff);
   assign abs_p   = acc_ff[AW-1] ? unsigned'(-acc_ext) : unsigned'(acc_ext);

   assign status.p_pos    = !acc_ff[AW-1] && (acc_ff != '0);
   assign status.p_in_tol = abs_p <= (AW+1)'(tolerance);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      x_in      = x_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      th_in     = th_ff;
      sum_in    = sum_ff;
      feas_in   = feas_ff;
      infeas_in = infeas_ff;
      if (cmd.load) begin
         x_in   = req_right_end;
         acc_in = AW'(req_coef_cube);
      end
      if (cmd.mid) begin
         x_in   = mid_point;
         acc_in = AW'(c3_ff);
      end
      if (cmd.mul_lo) begin
         prod_in = mul_res;
      end
      if (cmd.mul_hi) begin
         th_in   = prod_ff[PW-1:FRAC_SPLIT];
         prod_in = mul_res;
      end
      if (cmd.add) begin
         sum_in = prod_ff + PW'(th_ff);
      end
      if (cmd.acc) begin
         acc_in = total_sat;
      end
      if (cmd.update) begin
         if (status.p_pos) begin
            feas_in = x_ff;
         end else begin
            infeas_in = x_ff;
         end
      end
   end

   always_comb begin
      root_in      = root_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.out_write) begin
         root_in      = cmd.out_early ? infeas_ff : feas_ff;
         flag_in      = cmd.out_early;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         c0_ff <= req_coef_const;
         c1_ff <= req_coef_linear;
         c2_ff <= req_coef_square;
         c3_ff <= req_coef_cube;
      end
      if (cmd.load) begin
         feas_ff   <= req_left_end;
         infeas_ff <= req_right_end;
      end else begin
         feas_ff   <= feas_in;
         infeas_ff <= infeas_in;
      end
      x_ff    <= x_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      th_ff   <= th_in;
      sum_ff  <= sum_in;
      root_ff <= root_in;
      flag_ff <= flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_root           = root_ff;
   assign rsp_right_was_root = flag_ff;

endmodule

/* sv/cubic_bisection_root_finder.sv */
// Cubic bisection root finder.
//
// The req channel carries one transaction per problem: four signed Q8.24
// coefficients of p(x) and a left (feasible) and right (infeasible) end in
// signed Q4.28. The rsp channel returns one transaction per request: the
// root in Q4.28 and a flag that is set when the right end itself met the
// tolerance. Both channels use valid/ready; the block takes one request at a
// time, and req_ready is high only while the controller is idle.
// Each bisection step runs three Horner steps on one shared 25x32 multiplier
// (low product, high product, carry sum, saturating accumulate), plus a
// midpoint step and a test step; the first evaluation at the right end has
// no midpoint step. A request that exits on the right end needs that one
// evaluation; otherwise ITERATIONS + 1 evaluations run. The next request can
// be accepted in the cycle after the result is written. The result waits in
// an output register: a stalled rsp_ready holds it there, and a following
// result stalls the controller until it drains. A synchronous reset returns
// to idle, empties the output register and sets the tolerance register (csr
// byte address 0, 31 bits) to zero.
module cubic_bisection_root_finder #(
   parameter int ITERATIONS = cbrf_pkg::ITERATIONS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [cbrf_pkg::DATA_W-1:0]    req_coef_const,
   input  logic signed [cbrf_pkg::DATA_W-1:0]    req_coef_linear,
   input  logic signed [cbrf_pkg::DATA_W-1:0]    req_coef_square,
   input  logic signed [cbrf_pkg::DATA_W-1:0]    req_coef_cube,
   input  logic signed [cbrf_pkg::DATA_W-1:0]    req_left_end,
   input  logic signed [cbrf_pkg::DATA_W-1:0]    req_right_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [cbrf_pkg::DATA_W-1:0]    rsp_root,
   output logic                                  rsp_right_was_root,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic        [cbrf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic        [cbrf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic        [cbrf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                  csr_pready
);

   localparam int TW = cbrf_pkg::TOL_W;

   logic [TW-1:0] tol_ff, tol_in;
   logic          csr_hit;

   cbrf_pkg::dp_cmd_type    cmd;
   cbrf_pkg::dp_status_type status;

   // Bit 2 of the byte address is the register index; low bits are ignored.
   assign csr_hit = (csr_paddr[2] == cbrf_pkg::CSR_IDX_TOLERANCE);

   always_comb begin
      tol_in = tol_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         tol_in = csr_pwdata[TW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else begin
         tol_ff <= tol_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? cbrf_pkg::CSR_DATA_W'(tol_ff) : '0;

   cbrf_ctrl #(
      .ITERATIONS (ITERATIONS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cbrf_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .tolerance          (tol_ff),
      .req_coef_const     (req_coef_const),
      .req_coef_linear    (req_coef_linear),
      .req_coef_square    (req_coef_square),
      .req_coef_cube      (req_coef_cube),
      .req_left_end       (req_left_end),
      .req_right_end      (req_right_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_root           (rsp_root),
      .rsp_right_was_root (rsp_right_was_root)
   );

endmodule

/* sv/cbrf_checker.sv */
// Port-level checker of the cubic bisection root finder, bound to the top.
// Depends on cbrf_pkg and cubic_bisection_root_finder_macros.svh.
`include "cubic_bisection_root_finder_macros.svh"

module cbrf_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [cbrf_pkg::DATA_W-1:0]    rsp_root,
   input logic                                  rsp_right_was_root,
   input logic                                  csr_psel,
   input logic                                  csr_penable,
   input logic                                  csr_pwrite,
   input logic                                  csr_pready,
   input logic        [cbrf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic        [cbrf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic        [cbrf_pkg::CSR_DATA_W-1:0] csr_prdata
);

   // A stalled result transaction keeps its payload.
   `CBRF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_root) && $stable(rsp_right_was_root), "rsp payload changed under stall")

   // The block works on one request at a time.
   `CBRF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "request accepted while busy")

   // A tolerance write reads back on the following cycle.
   `CBRF_ASSERT_NEXT(a_tol_readback, clock, reset, csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2], csr_paddr[2] || (csr_prdata[31] == 1'b0 && csr_prdata[30:0] == $past(csr_pwdata[30:0])), "tolerance readback mismatch")

   // The top bit of the tolerance register never reads as set.
   `CBRF_ASSERT_SAME(a_prdata_top, clock, reset, csr_psel, csr_prdata[31] == 1'b0, "prdata top bit set")

endmodule

bind cubic_bisection_root_finder cbrf_checker u_cbrf_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_root           (rsp_root),
   .rsp_right_was_root (rsp_right_was_root),
   .csr_psel           (csr_psel),
   .csr_penable        (csr_penable),
   .csr_pwrite         (csr_pwrite),
   .csr_pready         (csr_pready),
   .csr_paddr          (csr_paddr),
   .csr_pwdata         (csr_pwdata),
   .csr_prdata         (csr_prdata)
);
